// ----- hw/rtl/lpi_pkg.sv -----
// Shared types and defaults for the line pair intersection block.
// No dependencies; every other file in hw/rtl imports this package.
package lpi_pkg;

    localparam int COORD_BITS_DEF = 16;  // default coordinate width
    localparam int IN_FIELD_W     = 16;  // width of one input field in tdata
    localparam int OUT_COORD_W    = 32;  // width of one result coordinate

    // control that rides along the divider chain
    typedef struct packed {
        logic vld;    // stage holds an item
        logic hit;    // cross product nonzero
        logic neg_x;  // sign of the x offset term
        logic neg_y;  // sign of the y offset term
    } lpi_ctl_t;

endpackage

// ----- hw/rtl/lpi_div_cell.sv -----
// One cell of the restoring divider chain: resolves one quotient bit for x and y lanes.
// Depends on lpi_pkg (control struct).
module lpi_div_cell #(
    parameter int DEN_W  = 33,
    parameter int Q_W    = 49,
    parameter int BIT    = 48,
    parameter int SIDE_W = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  lpi_pkg::lpi_ctl_t       ctl_in,
    input  logic [SIDE_W-1:0]       side_in,
    input  logic [DEN_W-1:0]        den_in,
    input  logic [Q_W-1:0]          nq_x_in,
    input  logic [Q_W-1:0]          nq_y_in,
    input  logic [DEN_W-1:0]        rem_x_in,
    input  logic [DEN_W-1:0]        rem_y_in,
    output lpi_pkg::lpi_ctl_t       ctl_out,
    output logic [SIDE_W-1:0]       side_out,
    output logic [DEN_W-1:0]        den_out,
    output logic [Q_W-1:0]          nq_x_out,
    output logic [Q_W-1:0]          nq_y_out,
    output logic [DEN_W-1:0]        rem_x_out,
    output logic [DEN_W-1:0]        rem_y_out
);
    import lpi_pkg::*;

    logic [DEN_W:0]   tx, ty, dx, dy;
    logic             ge_x, ge_y;
    logic [DEN_W-1:0] rem_x_next, rem_y_next;
    logic [Q_W-1:0]   nq_x_next, nq_y_next;
    lpi_ctl_t         ctl_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [DEN_W-1:0] den_reg, rem_x_reg, rem_y_reg;
    logic [Q_W-1:0]   nq_x_reg, nq_y_reg;

    // shift in the numerator bit; it is replaced by the quotient bit
    always_comb begin
        tx   = {rem_x_in, nq_x_in[BIT]};
        ty   = {rem_y_in, nq_y_in[BIT]};
        ge_x = tx >= {1'b0, den_in};
        ge_y = ty >= {1'b0, den_in};
        dx   = tx - {1'b0, den_in};
        dy   = ty - {1'b0, den_in};
        rem_x_next = ge_x ? dx[DEN_W-1:0] : tx[DEN_W-1:0];
        rem_y_next = ge_y ? dy[DEN_W-1:0] : ty[DEN_W-1:0];
        nq_x_next = nq_x_in;
        nq_y_next = nq_y_in;
        nq_x_next[BIT] = ge_x;
        nq_y_next[BIT] = ge_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg  <= side_in;
            den_reg   <= den_in;
            nq_x_reg  <= nq_x_next;
            nq_y_reg  <= nq_y_next;
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign side_out  = side_reg;
    assign den_out   = den_reg;
    assign nq_x_out  = nq_x_reg;
    assign nq_y_out  = nq_y_reg;
    assign rem_x_out = rem_x_reg;
    assign rem_y_out = rem_y_reg;

endmodule

// ----- hw/rtl/lpi_round.sv -----
// Final sign fix, round half to even and 32-bit saturation of one coordinate.
// Depends on lpi_pkg (output width).
module lpi_round #(
    parameter int COORD_BITS = lpi_pkg::COORD_BITS_DEF
) (
    input  logic                          hit,
    input  logic                          neg,
    input  logic signed [COORD_BITS-1:0]  base,
    input  logic [3*COORD_BITS:0]         quo,
    input  logic [2*COORD_BITS:0]         rem,
    input  logic [2*COORD_BITS:0]         den,
    output logic [lpi_pkg::OUT_COORD_W-1:0] coord
);
    import lpi_pkg::*;

    localparam int QW   = 3 * COORD_BITS + 1;
    localparam int DENW = 2 * COORD_BITS + 1;
    localparam int QXW  = QW + 42;
    localparam int VW   = 44;

    logic [QXW-1:0]       qx;
    logic                 sat, odd, up;
    logic signed [VW-1:0] vm, v, v2, v3;
    logic [DENW-1:0]      rr;
    logic [DENW:0]        r2;

    always_comb begin
        qx  = QXW'(quo);
        sat = qx > (QXW'(1) << 40);
        vm  = signed'({3'b000, qx[40:0]});
        if (neg && (rem != '0)) begin
            v  = -(vm + VW'(1));
            rr = den - rem;
        end else if (neg) begin
            v  = -vm;
            rr = rem;
        end else begin
            v  = vm;
            rr = rem;
        end
        v2  = v + VW'(base);
        odd = v2[0];
        r2  = {rr, 1'b0};
        up  = (r2 > {1'b0, den}) || ((r2 == {1'b0, den}) && odd);
        v3  = v2 + (up ? VW'(1) : VW'(0));
        priority if (!hit) begin
            coord = '0;
        end else if (sat) begin
            coord = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (v3 > 44'sd2147483647) begin
            coord = 32'h7FFF_FFFF;
        end else if (v3 < -44'sd2147483648) begin
            coord = 32'h8000_0000;
        end else begin
            coord = v3[OUT_COORD_W-1:0];
        end
    end

endmodule

// ----- hw/rtl/line_pair_intersection_top.sv -----
// Line pair intersection: front end of products, divider cell chain, rounding.
// Depends on lpi_pkg, lpi_div_cell and lpi_round.
// From input accept to result valid: four front stages, one divider cell per
//   quotient bit, then the output register.
// Throughput: one item per cycle; every stage stalls together on back-pressure.
// Reset: aresetn, synchronous, active low; clears all valid flags, payloads stay.
module line_pair_intersection_top #(
    parameter int COORD_BITS = lpi_pkg::COORD_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // first_ax, first_ay, second_ax, second_ay, first_bx, first_by,
    // second_bx, second_by; 16 bits each from bit 0 up
    input  logic [127:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // cross_x [31:0], cross_y [63:32]
    output logic [63:0]   m_tdata,
    // hit
    output logic [0:0]    m_tuser
);
    import lpi_pkg::*;

    localparam int N    = COORD_BITS;
    localparam int DW   = N + 1;       // coordinate differences
    localparam int PW   = 2 * N + 2;   // raw products
    localparam int CW   = 2 * N + 3;   // cross products
    localparam int DENW = 2 * N + 1;   // divisor magnitude
    localparam int QW   = 3 * N + 1;   // dividend / quotient
    localparam int SW   = 2 * N;       // base point riding the chain

    // whole pipe advances when the output register is free or drained
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---- stage 1: pick base points, form direction and offset vectors ----
    logic signed [N-1:0]  p0, p1, p2, p3, p4, p5, p6, p7;
    logic signed [N-1:0]  abx_next, aby_next, aox, aoy, bbx, bby, box, boy;
    logic signed [DW-1:0] d1x_next, d1y_next, d2x_next, d2y_next, wx_next, wy_next;

    always_comb begin
        p0 = s_tdata[N-1:0];
        p1 = s_tdata[IN_FIELD_W   +: N];
        p2 = s_tdata[2*IN_FIELD_W +: N];
        p3 = s_tdata[3*IN_FIELD_W +: N];
        p4 = s_tdata[4*IN_FIELD_W +: N];
        p5 = s_tdata[5*IN_FIELD_W +: N];
        p6 = s_tdata[6*IN_FIELD_W +: N];
        p7 = s_tdata[7*IN_FIELD_W +: N];
        // tie in x: second point is the base
        if (p0 > p2) begin
            abx_next = p0; aby_next = p1; aox = p2; aoy = p3;
        end else begin
            abx_next = p2; aby_next = p3; aox = p0; aoy = p1;
        end
        if (p4 > p6) begin
            bbx = p4; bby = p5; box = p6; boy = p7;
        end else begin
            bbx = p6; bby = p7; box = p4; boy = p5;
        end
        d1x_next = DW'(aox) - DW'(abx_next);
        d1y_next = DW'(aoy) - DW'(aby_next);
        d2x_next = DW'(box) - DW'(bbx);
        d2y_next = DW'(boy) - DW'(bby);
        wx_next  = DW'(bbx) - DW'(abx_next);
        wy_next  = DW'(bby) - DW'(aby_next);
    end

    logic                 v1_reg, v2_reg, v3_reg;
    logic signed [N-1:0]  abx1_reg, aby1_reg, abx2_reg, aby2_reg, abx3_reg, aby3_reg;
    logic signed [DW-1:0] d1x_reg, d1y_reg, d2x_reg, d2y_reg, wx_reg, wy_reg;
    logic signed [DW-1:0] d1x2_reg, d1y2_reg, d1x3_reg, d1y3_reg;
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [CW-1:0] c_reg, n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 1
            abx1_reg <= abx_next;
            aby1_reg <= aby_next;
            d1x_reg  <= d1x_next;
            d1y_reg  <= d1y_next;
            d2x_reg  <= d2x_next;
            d2y_reg  <= d2y_next;
            wx_reg   <= wx_next;
            wy_reg   <= wy_next;
            // stage 2: the four products
            pa_reg   <= PW'(d1x_reg * d2y_reg);
            pb_reg   <= PW'(d1y_reg * d2x_reg);
            pc_reg   <= PW'(wx_reg * d2y_reg);
            pd_reg   <= PW'(wy_reg * d2x_reg);
            abx2_reg <= abx1_reg;
            aby2_reg <= aby1_reg;
            d1x2_reg <= d1x_reg;
            d1y2_reg <= d1y_reg;
            // stage 3: cross products c and n
            c_reg    <= CW'(pa_reg) - CW'(pb_reg);
            n_reg    <= CW'(pc_reg) - CW'(pd_reg);
            abx3_reg <= abx2_reg;
            aby3_reg <= aby2_reg;
            d1x3_reg <= d1x2_reg;
            d1y3_reg <= d1y2_reg;
        end
    end

    // ---- stage 4: magnitudes and dividends, feeds the first cell ----
    logic [CW-1:0]   c_abs, n_abs;
    logic [DW-1:0]   dx_abs, dy_abs;
    logic [DENW-1:0] den_next, nmag;
    logic [QW-1:0]   numx_next, numy_next;
    lpi_ctl_t        ctl_next;

    always_comb begin
        c_abs  = c_reg[CW-1] ? CW'(-c_reg) : CW'(c_reg);
        n_abs  = n_reg[CW-1] ? CW'(-n_reg) : CW'(n_reg);
        dx_abs = d1x3_reg[DW-1] ? DW'(-d1x3_reg) : DW'(d1x3_reg);
        dy_abs = d1y3_reg[DW-1] ? DW'(-d1y3_reg) : DW'(d1y3_reg);
        den_next  = c_abs[DENW-1:0];
        nmag      = n_abs[DENW-1:0];
        numx_next = QW'(dx_abs[N-1:0]) * QW'(nmag);
        numy_next = QW'(dy_abs[N-1:0]) * QW'(nmag);
        ctl_next.vld   = v3_reg;
        ctl_next.hit   = c_reg != '0;
        ctl_next.neg_x = d1x3_reg[DW-1] ^ n_reg[CW-1] ^ c_reg[CW-1];
        ctl_next.neg_y = d1y3_reg[DW-1] ^ n_reg[CW-1] ^ c_reg[CW-1];
    end

    lpi_ctl_t        ctl_c  [0:QW];
    logic [SW-1:0]   side_c [0:QW];
    logic [DENW-1:0] den_c  [0:QW];
    logic [QW-1:0]   nqx_c  [0:QW];
    logic [QW-1:0]   nqy_c  [0:QW];
    logic [DENW-1:0] rx_c   [0:QW];
    logic [DENW-1:0] ry_c   [0:QW];
    lpi_ctl_t        ctl4_reg;
    logic [SW-1:0]   side4_reg;
    logic [DENW-1:0] den4_reg;
    logic [QW-1:0]   nqx4_reg, nqy4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl4_reg <= '0;
        end else if (adv) begin
            ctl4_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side4_reg <= {aby3_reg, abx3_reg};
            den4_reg  <= den_next;
            nqx4_reg  <= numx_next;
            nqy4_reg  <= numy_next;
        end
    end

    assign ctl_c[0]  = ctl4_reg;
    assign side_c[0] = side4_reg;
    assign den_c[0]  = den4_reg;
    assign nqx_c[0]  = nqx4_reg;
    assign nqy_c[0]  = nqy4_reg;
    assign rx_c[0]   = '0;
    assign ry_c[0]   = '0;

    // ---- divider chain: cell i settles quotient bit QW-1-i ----
    for (genvar i = 0; i < QW; i++) begin : g_cell
        lpi_div_cell #(
            .DEN_W  (DENW),
            .Q_W    (QW),
            .BIT    (QW - 1 - i),
            .SIDE_W (SW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .ctl_in    (ctl_c[i]),
            .side_in   (side_c[i]),
            .den_in    (den_c[i]),
            .nq_x_in   (nqx_c[i]),
            .nq_y_in   (nqy_c[i]),
            .rem_x_in  (rx_c[i]),
            .rem_y_in  (ry_c[i]),
            .ctl_out   (ctl_c[i+1]),
            .side_out  (side_c[i+1]),
            .den_out   (den_c[i+1]),
            .nq_x_out  (nqx_c[i+1]),
            .nq_y_out  (nqy_c[i+1]),
            .rem_x_out (rx_c[i+1]),
            .rem_y_out (ry_c[i+1])
        );
    end

    // ---- rounding and output register ----
    logic [OUT_COORD_W-1:0] cx_next, cy_next;

    lpi_round #(.COORD_BITS(N)) u_round_x (
        .hit   (ctl_c[QW].hit),
        .neg   (ctl_c[QW].neg_x),
        .base  (side_c[QW][N-1:0]),
        .quo   (nqx_c[QW]),
        .rem   (rx_c[QW]),
        .den   (den_c[QW]),
        .coord (cx_next)
    );

    lpi_round #(.COORD_BITS(N)) u_round_y (
        .hit   (ctl_c[QW].hit),
        .neg   (ctl_c[QW].neg_y),
        .base  (side_c[QW][SW-1:N]),
        .quo   (nqy_c[QW]),
        .rem   (ry_c[QW]),
        .den   (den_c[QW]),
        .coord (cy_next)
    );

    logic        m_valid_reg;
    logic [63:0] m_data_reg;
    logic        m_hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= ctl_c[QW].vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= {cy_next, cx_next};
            m_hit_reg  <= ctl_c[QW].hit;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_hit_reg;

    // ---- checks ----
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("parallel lines gave nonzero coordinates");
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(ctl_c[QW]))
        else $error("divider chain moved during stall");

endmodule
